// ----- hdl/flow_sequence_cuckoo_tracker_top_defines.svh -----
// ---------------------------------------------------------------------------
// Flow sequence cuckoo tracker assertion macros
// Shared concurrent assertion forms for the tracker modules.
// ---------------------------------------------------------------------------
`ifndef FLOW_SEQUENCE_CUCKOO_TRACKER_TOP_DEFINES_SVH
`define FLOW_SEQUENCE_CUCKOO_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define FSCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fsct: same-cycle check failed");

// next-cycle implication
`define FSCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fsct: next-cycle check failed");

`endif

// ----- hdl/fsct_pkg.sv -----
// ---------------------------------------------------------------------------
// Flow sequence cuckoo tracker package
// Entry type, hash constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fsct_pkg;

    localparam int MOD_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2      = 32'h1b873593;
    localparam logic [31:0] MM_C3      = 32'h85ebca6b;
    localparam logic [31:0] MM_C4      = 32'hc2b2ae35;
    localparam logic [31:0] MM_ADD     = 32'he6546b64;
    localparam logic [31:0] KEY_BYTES  = 32'd12;

    localparam logic [2:0] OUT_NEWER     = 3'd0;
    localparam logic [2:0] OUT_REORDER   = 3'd1;
    localparam logic [2:0] OUT_NEW_ONE   = 3'd2;
    localparam logic [2:0] OUT_NEW_TWO   = 3'd3;
    localparam logic [2:0] OUT_DISPLACED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_SEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_SEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SEED = 2'd2;

    localparam logic [1:0] SEL_ONE    = 2'd0;
    localparam logic [1:0] SEL_TWO    = 2'd1;
    localparam logic [1:0] SEL_BUCKET = 2'd2;
    localparam logic [1:0] SEL_KICK   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [63:0] addr;
        logic [31:0] ports;
        logic [31:0] seq;
    } t_entry;

    typedef struct packed {
        logic       clear;
        logic       latch_key;
        logic       hash_start;
        logic [1:0] hash_sel;
        logic       cap_i1;
        logic       cap_i2;
        logic       cap_kidx;
        logic       kick_addr;
        logic       kick_init;
        logic       kick_swap;
        logic       wr_key_one;
        logic       wr_key_two;
        logic       emit;
        logic [2:0] outcome;
        logic       use_bucket;
        logic       dropped;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_done;
        logic clear_last;
        logic hit;
        logic hit_one;
        logic newer;
        logic one_valid;
        logic two_valid;
        logic swap_valid;
    } t_dp_sts;

endpackage

// ----- hdl/flow_sequence_cuckoo_tracker_top.sv -----
// ---------------------------------------------------------------------------
// Flow sequence cuckoo tracker
// Two-way cuckoo flow table tracking the last sequence number per flow.
// ---------------------------------------------------------------------------
// A packet is taken when i_start is high and o_busy low; exactly one result
// follows as a one-cycle o_result_strobe, which the receiver cannot hold off.
// Every hash runs on one shared iterative MurmurHash unit, with a reciprocal
// remainder step when the modulus is not a power of two.
// A packet costs two hashes plus the IDLE, HGO1, RD and EVAL states;
// an out-of-order report adds one bucket hash; displacement adds the KREAD
// and KSWAP states for the first swap and one hash plus the KHGO, KREAD and
// KSWAP states for each further swap, up to KICK_LIMIT swaps.
// After reset every entry of both tables is cleared with o_busy high;
// configuration writes are taken at any time (o_cfg_ready is always high).
// ---------------------------------------------------------------------------
module flow_sequence_cuckoo_tracker_top #(
    parameter int SIDE_DEPTH   = 1024,
    parameter int BUCKET_COUNT = 256,
    parameter int KICK_LIMIT   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fsct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [31:0]                     i_src_ip,
    input  logic [15:0]                     i_src_port,
    input  logic [31:0]                     i_dst_ip,
    input  logic [15:0]                     i_dst_port,
    input  logic [31:0]                     i_seq,
    output logic                            o_result_strobe,
    output logic [2:0]                      o_outcome,
    output logic [7:0]                      o_bucket_index,
    output logic                            o_dropped_valid
);

    fsct_pkg::t_dp_cmd cmd;
    fsct_pkg::t_dp_sts sts;
    logic              busy;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = busy;

    fsct_ctrl #(.KICK_LIMIT(KICK_LIMIT)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fsct_datapath #(
        .SIDE_DEPTH   (SIDE_DEPTH),
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_src_ip        (i_src_ip),
        .i_src_port      (i_src_port),
        .i_dst_ip        (i_dst_ip),
        .i_dst_port      (i_dst_port),
        .i_seq           (i_seq),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_result_strobe (o_result_strobe),
        .o_outcome       (o_outcome),
        .o_bucket_index  (o_bucket_index),
        .o_dropped_valid (o_dropped_valid)
    );

endmodule

// ----- hdl/fsct_table.sv -----
// ---------------------------------------------------------------------------
// Flow table memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fsct_table #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  fsct_pkg::t_entry    i_wdata,
    input  logic [IDX_W-1:0]    i_raddr,
    output fsct_pkg::t_entry    o_rdata
);

    fsct_pkg::t_entry mem [DEPTH];
    fsct_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fsct_hash.sv -----
// ---------------------------------------------------------------------------
// Key hash unit
// Iterative MurmurHash3 x86_32 over the 12-byte key, one multiply per cycle,
// followed by a reciprocal-multiply remainder (mask when the modulus is a
// power of two).
// ---------------------------------------------------------------------------
module fsct_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [63:0]                 i_addr,
    input  logic [31:0]                 i_ports,
    input  logic [31:0]                 i_seed,
    input  logic [fsct_pkg::MOD_W-1:0]  i_mod,
    input  logic [31:0]                 i_recip,
    output logic                        o_done,
    output logic [fsct_pkg::MOD_W-1:0]  o_result
);

    localparam int MW = fsct_pkg::MOD_W;

    localparam logic [3:0] HS_IDLE = 4'd0;
    localparam logic [3:0] HS_MIX0 = 4'd1;
    localparam logic [3:0] HS_MIX1 = 4'd2;
    localparam logic [3:0] HS_MIX2 = 4'd3;
    localparam logic [3:0] HS_FIN0 = 4'd4;
    localparam logic [3:0] HS_FIN1 = 4'd5;
    localparam logic [3:0] HS_FIN2 = 4'd6;
    localparam logic [3:0] HS_MODQ = 4'd7;
    localparam logic [3:0] HS_MODR = 4'd8;
    localparam logic [3:0] HS_MODC = 4'd9;

    logic [3:0]    r_hs;
    logic [1:0]    r_blk;
    logic [31:0]   r_h;
    logic [31:0]   r_k;
    logic [31:0]   r_b0;
    logic [31:0]   r_b1;
    logic [31:0]   r_b2;
    logic [MW-1:0] r_mod;
    logic [31:0]   r_recip;
    logic [31:0]   r_q;
    logic [31:0]   r_rem;
    logic [MW-1:0] r_res;
    logic          r_done;

    logic [31:0] blk;
    logic [31:0] k_mul1;
    logic [31:0] k_rot;
    logic [31:0] k_mul2;
    logic [31:0] hx;
    logic [31:0] h_rot;
    logic [31:0] h_upd;
    logic [31:0] f0;
    logic [31:0] f0s;
    logic [31:0] f0m;
    logic [31:0] f1;
    logic [31:0] f1m;
    logic [31:0] f2;
    logic [MW-1:0] mask;
    logic          pow2;
    logic [31:0]   mod_ext;
    logic [63:0]   q_prod;
    logic [31:0]   qm;
    logic [31:0]   rem_fix;

    always_comb begin
        unique case (r_blk)
            2'd0:    blk = r_b0;
            2'd1:    blk = r_b1;
            default: blk = r_b2;
        endcase
    end

    assign k_mul1 = blk * fsct_pkg::MM_C1;
    assign k_rot  = {r_k[16:0], r_k[31:17]};
    assign k_mul2 = k_rot * fsct_pkg::MM_C2;
    assign hx     = r_h ^ r_k;
    assign h_rot  = {hx[18:0], hx[31:19]};
    assign h_upd  = (h_rot << 2) + h_rot + fsct_pkg::MM_ADD;
    assign f0     = r_h ^ fsct_pkg::KEY_BYTES;
    assign f0s    = f0 ^ (f0 >> 16);
    assign f0m    = f0s * fsct_pkg::MM_C3;
    assign f1     = r_h ^ (r_h >> 13);
    assign f1m    = f1 * fsct_pkg::MM_C4;
    assign f2     = r_h ^ (r_h >> 16);
    assign mask   = r_mod - MW'(1);
    assign pow2   = (r_mod & mask) == '0;

    // quotient estimate is low by at most one, so one correction step
    assign mod_ext = {{(32-MW){1'b0}}, r_mod};
    assign q_prod  = {32'd0, r_h} * {32'd0, r_recip};
    assign qm      = r_q * mod_ext;
    assign rem_fix = (r_rem >= mod_ext) ? (r_rem - mod_ext) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs   <= HS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_hs)
                HS_IDLE: begin
                    if (i_start) begin
                        r_hs <= HS_MIX0;
                    end
                end
                HS_MIX0: r_hs <= HS_MIX1;
                HS_MIX1: r_hs <= HS_MIX2;
                HS_MIX2: r_hs <= (r_blk == 2'd2) ? HS_FIN0 : HS_MIX0;
                HS_FIN0: r_hs <= HS_FIN1;
                HS_FIN1: r_hs <= HS_FIN2;
                HS_FIN2: begin
                    if (pow2) begin
                        r_hs   <= HS_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_hs <= HS_MODQ;
                    end
                end
                HS_MODQ: r_hs <= HS_MODR;
                HS_MODR: r_hs <= HS_MODC;
                HS_MODC: begin
                    r_hs   <= HS_IDLE;
                    r_done <= 1'b1;
                end
                default: r_hs <= HS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_hs)
            HS_IDLE: begin
                if (i_start) begin
                    r_h     <= i_seed;
                    r_blk   <= 2'd0;
                    r_b0    <= i_addr[63:32];
                    r_b1    <= {i_addr[15:0], i_ports[31:16]};
                    r_b2    <= {i_ports[15:0], i_addr[31:16]};
                    r_mod   <= i_mod;
                    r_recip <= i_recip;
                end
            end
            HS_MIX0: r_k <= k_mul1;
            HS_MIX1: r_k <= k_mul2;
            HS_MIX2: begin
                r_h   <= h_upd;
                r_blk <= r_blk + 2'd1;
            end
            HS_FIN0: r_h <= f0m;
            HS_FIN1: r_h <= f1m;
            HS_FIN2: begin
                r_h   <= f2;
                r_res <= f2[MW-1:0] & mask;
            end
            HS_MODQ: r_q   <= q_prod[63:32];
            HS_MODR: r_rem <= r_h - qm;
            HS_MODC: r_res <= rem_fix[MW-1:0];
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- hdl/fsct_datapath.sv -----
// ---------------------------------------------------------------------------
// Tracker datapath
// Seeds, packet key, slot indexes, displacement carry, tables, hash unit
// and result registers.
// ---------------------------------------------------------------------------
module fsct_datapath #(
    parameter int SIDE_DEPTH   = 1024,
    parameter int BUCKET_COUNT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [fsct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [31:0]                         i_src_ip,
    input  logic [15:0]                         i_src_port,
    input  logic [31:0]                         i_dst_ip,
    input  logic [15:0]                         i_dst_port,
    input  logic [31:0]                         i_seq,
    input  fsct_pkg::t_dp_cmd                   i_cmd,
    output fsct_pkg::t_dp_sts                   o_sts,
    output logic                                o_result_strobe,
    output logic [2:0]                          o_outcome,
    output logic [7:0]                          o_bucket_index,
    output logic                                o_dropped_valid
);

    localparam int IDX_W = $clog2(SIDE_DEPTH);
    localparam int MW    = fsct_pkg::MOD_W;
    localparam logic [MW-1:0] SIDE_MOD   = MW'(SIDE_DEPTH);
    localparam logic [MW-1:0] BUCKET_MOD = MW'(BUCKET_COUNT);
    localparam logic [31:0] SIDE_RECIP   = 32'(64'h1_0000_0000 / 64'(SIDE_DEPTH));
    localparam logic [31:0] BUCKET_RECIP = 32'(64'h1_0000_0000 / 64'(BUCKET_COUNT));

    logic [13:0]      r_seed1;
    logic [13:0]      r_seed2;
    logic [9:0]       r_bseed;
    logic [63:0]      r_addr;
    logic [31:0]      r_ports;
    logic [31:0]      r_seq;
    logic [IDX_W-1:0] r_i1;
    logic [IDX_W-1:0] r_i2;
    logic [IDX_W-1:0] r_kidx;
    logic [IDX_W-1:0] r_clr;
    logic             r_side;
    fsct_pkg::t_entry r_carry;
    logic             r_strobe;
    logic [2:0]       r_outcome;
    logic [7:0]       r_bucket;
    logic             r_dropped;

    fsct_pkg::t_entry key_entry;
    fsct_pkg::t_entry rd1;
    fsct_pkg::t_entry rd2;
    fsct_pkg::t_entry wdata1;
    fsct_pkg::t_entry wdata2;
    logic             we1;
    logic             we2;
    logic [IDX_W-1:0] waddr1;
    logic [IDX_W-1:0] waddr2;
    logic [IDX_W-1:0] raddr1;
    logic [IDX_W-1:0] raddr2;
    logic [63:0]      h_addr;
    logic [31:0]      h_ports;
    logic [31:0]      h_seed;
    logic [MW-1:0]    h_mod;
    logic [31:0]      h_recip;
    logic             h_done;
    logic [MW-1:0]    h_res;
    logic             hit_one;
    logic             hit_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1 <= 14'd0;
            r_seed2 <= 14'd1;
            r_bseed <= 10'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fsct_pkg::REG_ONE_SEED:    r_seed1 <= i_cfg_data;
                fsct_pkg::REG_TWO_SEED:    r_seed2 <= i_cfg_data;
                fsct_pkg::REG_BUCKET_SEED: r_bseed <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign key_entry = '{valid: 1'b1, addr: r_addr, ports: r_ports, seq: r_seq};

    // hash operand selection
    always_comb begin
        h_addr  = r_addr;
        h_ports = r_ports;
        h_mod   = SIDE_MOD;
        h_recip = SIDE_RECIP;
        unique case (i_cmd.hash_sel)
            fsct_pkg::SEL_ONE:    h_seed = {18'd0, r_seed1};
            fsct_pkg::SEL_TWO:    h_seed = {18'd0, r_seed2};
            fsct_pkg::SEL_BUCKET: begin
                h_seed  = {22'd0, r_bseed};
                h_mod   = BUCKET_MOD;
                h_recip = BUCKET_RECIP;
            end
            default: begin
                h_seed  = r_side ? {18'd0, r_seed2} : {18'd0, r_seed1};
                h_addr  = r_carry.addr;
                h_ports = r_carry.ports;
            end
        endcase
    end

    fsct_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.hash_start),
        .i_addr   (h_addr),
        .i_ports  (h_ports),
        .i_seed   (h_seed),
        .i_mod    (h_mod),
        .i_recip  (h_recip),
        .o_done   (h_done),
        .o_result (h_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_key) begin
            r_addr  <= {i_src_ip, i_dst_ip};
            r_ports <= {i_src_port, i_dst_port};
            r_seq   <= i_seq;
        end
        if (i_cmd.cap_i1) begin
            r_i1 <= h_res[IDX_W-1:0];
        end
        if (i_cmd.cap_i2) begin
            r_i2 <= h_res[IDX_W-1:0];
        end
        if (i_cmd.cap_kidx) begin
            r_kidx <= h_res[IDX_W-1:0];
        end
        if (i_cmd.kick_init) begin
            r_carry <= key_entry;
            r_side  <= 1'b0;
            r_kidx  <= r_i1;
        end else if (i_cmd.kick_swap) begin
            r_carry <= r_side ? rd2 : rd1;
            r_side  <= ~r_side;
        end
    end

    // table write and read ports
    always_comb begin
        we1    = i_cmd.clear | i_cmd.wr_key_one | (i_cmd.kick_swap & ~r_side);
        we2    = i_cmd.clear | i_cmd.wr_key_two | (i_cmd.kick_swap & r_side);
        waddr1 = i_cmd.clear ? r_clr : (i_cmd.kick_swap ? r_kidx : r_i1);
        waddr2 = i_cmd.clear ? r_clr : (i_cmd.kick_swap ? r_kidx : r_i2);
        wdata1 = i_cmd.clear ? '0 : (i_cmd.kick_swap ? r_carry : key_entry);
        wdata2 = wdata1;
        raddr1 = i_cmd.kick_addr ? r_kidx : r_i1;
        raddr2 = i_cmd.kick_addr ? r_kidx : r_i2;
    end

    fsct_table #(.DEPTH(SIDE_DEPTH), .IDX_W(IDX_W)) u_table_one (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_raddr (raddr1),
        .o_rdata (rd1)
    );

    fsct_table #(.DEPTH(SIDE_DEPTH), .IDX_W(IDX_W)) u_table_two (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (waddr2),
        .i_wdata (wdata2),
        .i_raddr (raddr2),
        .o_rdata (rd2)
    );

    assign hit_one = rd1.valid && (rd1.addr == r_addr) && (rd1.ports == r_ports);
    assign hit_two = rd2.valid && (rd2.addr == r_addr) && (rd2.ports == r_ports);

    assign o_sts.hash_done  = h_done;
    assign o_sts.clear_last = r_clr == IDX_W'(SIDE_DEPTH - 1);
    assign o_sts.hit        = hit_one | hit_two;
    assign o_sts.hit_one    = hit_one;
    assign o_sts.newer      = (hit_one ? rd1.seq : rd2.seq) < r_seq;
    assign o_sts.one_valid  = rd1.valid;
    assign o_sts.two_valid  = rd2.valid;
    assign o_sts.swap_valid = r_side ? rd2.valid : rd1.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_outcome <= i_cmd.outcome;
            r_bucket  <= i_cmd.use_bucket ? h_res[7:0] : 8'd0;
            r_dropped <= i_cmd.dropped;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_outcome       = r_outcome;
    assign o_bucket_index  = r_bucket;
    assign o_dropped_valid = r_dropped;

endmodule

// ----- hdl/fsct_ctrl.sv -----
// ---------------------------------------------------------------------------
// Tracker controller
// Sequences clearing, lookup, update, insertion and cuckoo displacement.
// ---------------------------------------------------------------------------
`include "flow_sequence_cuckoo_tracker_top_defines.svh"

module fsct_ctrl #(
    parameter int KICK_LIMIT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  fsct_pkg::t_dp_sts  i_sts,
    output fsct_pkg::t_dp_cmd  o_cmd
);

    localparam int KW = $clog2(KICK_LIMIT + 1);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_HGO1   = 4'd2;
    localparam logic [3:0] ST_H1     = 4'd3;
    localparam logic [3:0] ST_H2     = 4'd4;
    localparam logic [3:0] ST_RD     = 4'd5;
    localparam logic [3:0] ST_EVAL   = 4'd6;
    localparam logic [3:0] ST_BWAIT  = 4'd7;
    localparam logic [3:0] ST_KREAD  = 4'd8;
    localparam logic [3:0] ST_KSWAP  = 4'd9;
    localparam logic [3:0] ST_KHGO   = 4'd10;
    localparam logic [3:0] ST_KHWAIT = 4'd11;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [KW-1:0] r_kcnt;
    logic [KW-1:0] n_kcnt;
    fsct_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_kcnt   = r_kcnt;
        unique case (r_state)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    cmd.latch_key = 1'b1;
                    n_state       = ST_HGO1;
                end
            end
            ST_HGO1: begin
                cmd.hash_start = 1'b1;
                cmd.hash_sel   = fsct_pkg::SEL_ONE;
                n_state        = ST_H1;
            end
            ST_H1: begin
                if (i_sts.hash_done) begin
                    cmd.cap_i1     = 1'b1;
                    cmd.hash_start = 1'b1;
                    cmd.hash_sel   = fsct_pkg::SEL_TWO;
                    n_state        = ST_H2;
                end
            end
            ST_H2: begin
                if (i_sts.hash_done) begin
                    cmd.cap_i2 = 1'b1;
                    n_state    = ST_RD;
                end
            end
            ST_RD: n_state = ST_EVAL;
            ST_EVAL: begin
                priority if (i_sts.hit) begin
                    if (i_sts.newer) begin
                        cmd.wr_key_one = i_sts.hit_one;
                        cmd.wr_key_two = ~i_sts.hit_one;
                        cmd.emit       = 1'b1;
                        cmd.outcome    = fsct_pkg::OUT_NEWER;
                        n_state        = ST_IDLE;
                    end else begin
                        cmd.hash_start = 1'b1;
                        cmd.hash_sel   = fsct_pkg::SEL_BUCKET;
                        n_state        = ST_BWAIT;
                    end
                end else if (!i_sts.one_valid) begin
                    cmd.wr_key_one = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.outcome    = fsct_pkg::OUT_NEW_ONE;
                    n_state        = ST_IDLE;
                end else if (!i_sts.two_valid) begin
                    cmd.wr_key_two = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.outcome    = fsct_pkg::OUT_NEW_TWO;
                    n_state        = ST_IDLE;
                end else begin
                    cmd.kick_init = 1'b1;
                    n_kcnt        = '0;
                    n_state       = ST_KREAD;
                end
            end
            ST_BWAIT: begin
                cmd.hash_sel = fsct_pkg::SEL_BUCKET;
                if (i_sts.hash_done) begin
                    cmd.emit       = 1'b1;
                    cmd.outcome    = fsct_pkg::OUT_REORDER;
                    cmd.use_bucket = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_KREAD: begin
                cmd.kick_addr = 1'b1;
                n_state       = ST_KSWAP;
            end
            ST_KSWAP: begin
                cmd.kick_swap = 1'b1;
                if (!i_sts.swap_valid || r_kcnt == KW'(KICK_LIMIT - 1)) begin
                    cmd.emit    = 1'b1;
                    cmd.outcome = fsct_pkg::OUT_DISPLACED;
                    cmd.dropped = i_sts.swap_valid;
                    n_state     = ST_IDLE;
                end else begin
                    n_kcnt  = r_kcnt + KW'(1);
                    n_state = ST_KHGO;
                end
            end
            ST_KHGO: begin
                cmd.hash_start = 1'b1;
                cmd.hash_sel   = fsct_pkg::SEL_KICK;
                n_state        = ST_KHWAIT;
            end
            ST_KHWAIT: begin
                cmd.hash_sel = fsct_pkg::SEL_KICK;
                if (i_sts.hash_done) begin
                    cmd.cap_kidx = 1'b1;
                    n_state      = ST_KREAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_kcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_kcnt  <= n_kcnt;
        end
    end

    assign o_busy = r_state != ST_IDLE;
    assign o_cmd  = cmd;

    `FSCT_ASSERT_NEXT(a_emit_single, i_clk, i_rst_n, cmd.emit, !cmd.emit)
    `FSCT_ASSERT_NEXT(a_accept_hash, i_clk, i_rst_n, i_start && !o_busy, cmd.hash_start)
    `FSCT_ASSERT_NEXT(a_hash_pending, i_clk, i_rst_n, cmd.hash_start, !i_sts.hash_done)
    `FSCT_ASSERT_SAME(a_kick_bound, i_clk, i_rst_n, r_state == ST_KSWAP, r_kcnt < KICK_LIMIT)

endmodule

// ----- tb/flow_sequence_cuckoo_tracker_checker.sv -----
// ---------------------------------------------------------------------------
// Flow sequence cuckoo tracker checker
// Watches the register, packet and result channels, keeps its own copy of
// both cuckoo tables, predicts one result per packet and compares each
// strobed result against the oldest prediction.
// ---------------------------------------------------------------------------
module flow_sequence_cuckoo_tracker_checker
    import fsct_pkg::*;
#(
    parameter int SIDE_DEPTH   = 1024,
    parameter int BUCKET_COUNT = 256,
    parameter int KICK_LIMIT   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [31:0]           i_src_ip,
    input  logic [15:0]           i_src_port,
    input  logic [31:0]           i_dst_ip,
    input  logic [15:0]           i_dst_port,
    input  logic [31:0]           i_seq,
    input  logic                  i_result_strobe,
    input  logic [2:0]            i_outcome,
    input  logic [7:0]            i_bucket_index,
    input  logic                  i_dropped_valid,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] bucket;
        logic       dropped;
    } t_verdict;

    logic [13:0] one_seed, two_seed;
    logic [9:0]  bkt_seed;
    t_entry      side_one [SIDE_DEPTH];
    t_entry      side_two [SIDE_DEPTH];
    t_verdict    verdict_q[$];
    int          errors;

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] mix(logic [31:0] h, logic [31:0] k);
        k = k * MM_C1;
        k = rotl(k, 15);
        k = k * MM_C2;
        h = h ^ k;
        h = rotl(h, 13);
        return h * 32'd5 + MM_ADD;
    endfunction

    function automatic logic [31:0] murmur(logic [63:0] addr, logic [31:0] ports,
                                           logic [31:0] seed);
        logic [31:0] h;
        h = mix(seed, addr[63:32]);
        h = mix(h, {addr[15:0], ports[31:16]});
        h = mix(h, {ports[15:0], addr[31:16]});
        h = h ^ KEY_BYTES;
        h = h ^ (h >> 16);
        h = h * MM_C3;
        h = h ^ (h >> 13);
        h = h * MM_C4;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int slot_of(logic [63:0] a, logic [31:0] p, logic [31:0] s);
        return int'(murmur(a, p, s) % SIDE_DEPTH);
    endfunction

    function automatic t_verdict track_packet(logic [63:0] addr, logic [31:0] ports,
                                              logic [31:0] seq);
        t_verdict v;
        t_entry   carry, held;
        int       i1, i2, idx, n;
        bit       on_one;
        v  = '0;
        i1 = slot_of(addr, ports, {18'd0, one_seed});
        i2 = slot_of(addr, ports, {18'd0, two_seed});
        carry = '{valid: 1'b1, addr: addr, ports: ports, seq: seq};
        if (side_one[i1].valid && side_one[i1].addr == addr && side_one[i1].ports == ports) begin
            if (side_one[i1].seq < seq) begin
                side_one[i1].seq = seq;
                v.outcome = OUT_NEWER;
            end else begin
                v.outcome = OUT_REORDER;
            end
        end else if (side_two[i2].valid && side_two[i2].addr == addr
                     && side_two[i2].ports == ports) begin
            if (side_two[i2].seq < seq) begin
                side_two[i2].seq = seq;
                v.outcome = OUT_NEWER;
            end else begin
                v.outcome = OUT_REORDER;
            end
        end else if (!side_one[i1].valid) begin
            side_one[i1] = carry;
            v.outcome = OUT_NEW_ONE;
        end else if (!side_two[i2].valid) begin
            side_two[i2] = carry;
            v.outcome = OUT_NEW_TWO;
        end else begin
            on_one = 1'b1;
            idx = i1;
            for (n = 0; n < KICK_LIMIT; n++) begin
                if (on_one) begin
                    held = side_one[idx];
                    side_one[idx] = carry;
                end else begin
                    held = side_two[idx];
                    side_two[idx] = carry;
                end
                carry = held;
                if (!carry.valid) break;
                idx = slot_of(carry.addr, carry.ports,
                              {18'd0, on_one ? two_seed : one_seed});
                on_one = !on_one;
            end
            v.outcome = OUT_DISPLACED;
            v.dropped = carry.valid;
        end
        if (v.outcome == OUT_REORDER)
            v.bucket = 8'(murmur(addr, ports, {22'd0, bkt_seed}) % BUCKET_COUNT);
        return v;
    endfunction

    assign o_errors  = errors;
    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            one_seed = 14'd0;
            two_seed = 14'd1;
            bkt_seed = 10'd2;
            foreach (side_one[i]) begin
                side_one[i] = '0;
                side_two[i] = '0;
            end
            verdict_q.delete();
            errors = 0;
        end else begin
            if (i_result_strobe) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result outcome %0d bucket %0d dropped %0d",
                             $time, i_outcome, i_bucket_index, i_dropped_valid);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_outcome !== want.outcome) begin
                        $display("%0t: outcome expected %0d actual %0d",
                                 $time, want.outcome, i_outcome);
                        errors++;
                    end
                    if (i_bucket_index !== want.bucket) begin
                        $display("%0t: bucket_index expected %0d actual %0d",
                                 $time, want.bucket, i_bucket_index);
                        errors++;
                    end
                    if (i_dropped_valid !== want.dropped) begin
                        $display("%0t: dropped_valid expected %0d actual %0d",
                                 $time, want.dropped, i_dropped_valid);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ONE_SEED:    one_seed = i_cfg_data;
                    REG_TWO_SEED:    two_seed = i_cfg_data;
                    REG_BUCKET_SEED: bkt_seed = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                verdict_q.push_back(track_packet({i_src_ip, i_dst_ip},
                                                 {i_src_port, i_dst_port}, i_seq));
        end
    end
endmodule

// ----- tb/tb_flow_sequence_cuckoo_tracker_top.sv -----
// ---------------------------------------------------------------------------
// Flow sequence cuckoo tracker testbench
// Drives directed and random packet streams (revisited flows, new flows,
// stale sequences and noise) across several seed settings with random gaps;
// the checker module predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_flow_sequence_cuckoo_tracker_top;
    import fsct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL      = 128;
    localparam int RAND_ITEMS = 1750;
    localparam int STALL_LIMIT = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [31:0]           i_src_ip = '0;
    logic [15:0]           i_src_port = '0;
    logic [31:0]           i_dst_ip = '0;
    logic [15:0]           i_dst_port = '0;
    logic [31:0]           i_seq = '0;
    logic                  o_result_strobe;
    logic [2:0]            o_outcome;
    logic [7:0]            o_bucket_index;
    logic                  o_dropped_valid;
    int                    errors, pending, stall_cycles;
    bit                    no_gaps;

    typedef struct {
        logic [31:0] sip, dip, seq;
        logic [15:0] sport, dport;
    } t_flow;
    t_flow flows[POOL];

    flow_sequence_cuckoo_tracker_top dut (.*);

    flow_sequence_cuckoo_tracker_checker checker_u (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_start, .i_busy(o_busy), .i_src_ip, .i_src_port, .i_dst_ip,
        .i_dst_port, .i_seq, .i_result_strobe(o_result_strobe), .i_outcome(o_outcome),
        .i_bucket_index(o_bucket_index), .i_dropped_valid(o_dropped_valid),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_strobe
            || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = no_gaps ? 0 : (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 4)
                                                  : $urandom_range(10, 60);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // start is left high after acceptance; idle_gap or the caller lowers it
    task automatic send_packet(t_flow f);
        idle_gap();
        i_start    <= 1'b1;
        i_src_ip   <= f.sip;
        i_src_port <= f.sport;
        i_dst_ip   <= f.dip;
        i_dst_port <= f.dport;
        i_seq      <= f.seq;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_flow random_flow();
        t_flow f;
        f.sip = $urandom; f.dip = $urandom; f.seq = $urandom;
        f.sport = 16'($urandom); f.dport = 16'($urandom);
        return f;
    endfunction

    task automatic random_traffic(int count);
        t_flow f;
        int    r, k;
        repeat (count) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL - 1);
            if (r < 45) begin
                flows[k] = random_flow();
                f = flows[k];
            end else if (r < 85) begin
                flows[k].seq = flows[k].seq + $urandom_range(1, 1000);
                f = flows[k];
            end else if (r < 95) begin
                f = flows[k];
                f.seq = f.seq - $urandom_range(0, 3);
            end else begin
                f = random_flow();
            end
            send_packet(f);
        end
    endtask

    initial begin
        t_flow f;
        foreach (flows[i]) flows[i] = random_flow();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, newer, equal and older sequences
        f = '{sip: '0, dip: '0, seq: '0, sport: '0, dport: '0};
        send_packet(f);
        send_packet(f);
        f.seq = 32'd1;
        send_packet(f);
        f = '{sip: '1, dip: '1, seq: '1, sport: '1, dport: '1};
        send_packet(f);
        send_packet(f);
        f.seq = 32'd5;
        send_packet(f);
        f = '{sip: 32'h8000_0001, dip: 32'h0000_ffff, seq: 32'h7fff_ffff,
              sport: 16'h8000, dport: 16'h00ff};
        send_packet(f);
        f.seq = 32'h8000_0000;
        send_packet(f);
        f.sport = 16'h8001;
        send_packet(f);
        no_gaps = 1'b1;
        random_traffic(12);
        no_gaps = 1'b0;
        random_traffic(400);
        drain();

        write_reg(REG_ONE_SEED, 14'd9999);
        write_reg(REG_TWO_SEED, 14'd0);
        write_reg(REG_BUCKET_SEED, 14'd999);
        random_traffic(450);
        drain();

        write_reg(REG_ONE_SEED, 14'h3fff);
        write_reg(REG_TWO_SEED, 14'h3fff - 14'd1);
        write_reg(REG_BUCKET_SEED, 14'h3fff);
        write_reg(2'd3, 14'h2aaa);
        no_gaps = 1'b1;
        random_traffic(150);
        no_gaps = 1'b0;
        random_traffic(300);
        drain();

        write_reg(REG_ONE_SEED, 14'd0);
        write_reg(REG_TWO_SEED, 14'd9999);
        write_reg(REG_BUCKET_SEED, 14'd0);
        random_traffic(450);
        drain();
        repeat (400) @(negedge i_clk);

        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fsct_pkg.sv
hdl/fsct_table.sv
hdl/fsct_hash.sv
hdl/fsct_datapath.sv
hdl/fsct_ctrl.sv
hdl/flow_sequence_cuckoo_tracker_top.sv
tb/flow_sequence_cuckoo_tracker_checker.sv
tb/tb_flow_sequence_cuckoo_tracker_top.sv
